/* hw/rtl/sfd_pkg.sv */
// Types, constants and step functions shared by the fixed-point divider files.
package sfd_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned DivSteps      = 32;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumDivStages  = DivSteps / StepsPerStage;
  // Input register, the division stages and the output register.
  localparam int unsigned PipeDepth     = NumDivStages + 2;

  localparam int unsigned FracQ16 = 16;
  localparam int unsigned FracQ30 = 30;

  localparam logic [DataW-1:0] SatNeg = 32'h8000_0000;
  localparam logic [DataW-1:0] SatPos = 32'h7FFF_FFFF;

  typedef enum logic {
    ModeQ16 = 1'b0,
    ModeQ30 = 1'b1
  } mode_t;

  // Operands after sign removal, held in the input register.
  typedef struct packed {
    mode_t            mode;
    logic             neg;
    logic [DataW-1:0] mag_n;
    logic [DataW-1:0] mag_d;
  } operand_t;

  // Working state of the restoring division as it moves down the pipe.
  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [DataW-1:0] d;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] low;
    logic [DataW-1:0] q;
  } div_stage_t;

  function automatic logic [DataW-1:0] magnitude(input logic [DataW-1:0] v);
    magnitude = v[DataW-1] ? (~v + 1'b1) : v;
  endfunction

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic div_stage_t div_step(input div_stage_t s);
    logic [DataW:0] trial;
    logic [DataW:0] diff;
    div_stage_t     r;
    r     = s;
    trial = {s.rem, s.low[DataW-1]};
    diff  = trial - {1'b0, s.d};
    r.low = {s.low[DataW-2:0], 1'b0};
    if (!diff[DataW]) begin
      r.rem = diff[DataW-1:0];
      r.q   = {s.q[DataW-2:0], 1'b1};
    end else begin
      r.rem = trial[DataW-1:0];
      r.q   = {s.q[DataW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/sfd_ifs.sv */
// Valid/ready channel interfaces for the divider's operand and quotient beats.
interface sfd_in_if;
  logic                           valid;
  logic                           ready;
  sfd_pkg::mode_t                 mode;
  logic signed [sfd_pkg::DataW-1:0] numerator;
  logic signed [sfd_pkg::DataW-1:0] denominator;

  modport source(output valid, output mode, output numerator, output denominator,
                 input ready);
  modport sink(input valid, input mode, input numerator, input denominator,
               output ready);
endinterface

interface sfd_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [sfd_pkg::DataW-1:0] quotient;

  modport source(output valid, output quotient, input ready);
  modport sink(input valid, input quotient, output ready);
endinterface

/* hw/rtl/saturating_fixed_divider.sv */
// Pipelined saturating signed fixed-point divider, top level.
//
// Operand beats arrive on in_chan (mode, numerator, denominator) and each one
// yields exactly one quotient beat on out_chan, in order. Mode selects 16.16
// or 2.30 format. Overflow and a zero divisor saturate to 0x7FFFFFFF, or to
// 0x80000000 when the operand signs differ.
//
// The datapath is an input register, eight division stages of four restoring
// steps each (one 33-bit subtract per step), and an output register; each
// beat passes through these registers in that order on its way to out_chan.
// One beat can be accepted every cycle while out_chan is not stalled; the eight
// division stages set that figure by holding 32 steps in flight at once.
//
// Every stage loads whenever it is empty or the stage after it moves, so a
// stalled receiver only backs up the pipeline until it is full; bubbles are
// squeezed out and in_chan.ready stays high while the output is empty.
// Synchronous reset clears all valid bits; payload registers are not reset.
module saturating_fixed_divider (
  input  logic      clk,
  input  logic      rst_n,
  sfd_in_if.sink    in_chan,
  sfd_out_if.source out_chan
);

  localparam int unsigned W = sfd_pkg::DataW;
  localparam int unsigned N = sfd_pkg::NumDivStages;

  // Input register.
  logic                 op_v_r;
  sfd_pkg::operand_t    op_r;
  sfd_pkg::operand_t    op_nxt;
  logic                 op_rdy;

  // Division stages.
  logic                 div_v_r [N];
  sfd_pkg::div_stage_t  div_r   [N];
  sfd_pkg::div_stage_t  div_nxt [N];
  logic                 div_rdy [N];
  sfd_pkg::div_stage_t  div_init;

  // Output register.
  logic                 out_v_r;
  logic [W-1:0]         out_q_r;
  logic [W-1:0]         out_q_nxt;
  logic                 out_rdy;

  assign out_rdy = !out_v_r || out_chan.ready;
  assign op_rdy  = !op_v_r || div_rdy[0];
  assign in_chan.ready = op_rdy;

  always_comb begin
    op_nxt.mode  = in_chan.mode;
    op_nxt.neg   = in_chan.numerator[W-1] ^ in_chan.denominator[W-1];
    op_nxt.mag_n = sfd_pkg::magnitude(in_chan.numerator);
    op_nxt.mag_d = sfd_pkg::magnitude(in_chan.denominator);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v_r <= 1'b0;
    end else if (op_rdy) begin
      op_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_rdy) begin
      op_r <= op_nxt;
    end
  end

  // The overflow test and the split of mag_n * 2^F into the initial partial
  // remainder and the bits still to be shifted in depend on the format.
  always_comb begin
    div_init.neg = op_r.neg;
    div_init.d   = op_r.mag_d;
    div_init.q   = '0;
    unique case (op_r.mode)
      sfd_pkg::ModeQ30: begin
        div_init.sat = (op_r.mag_n >> (W - 1 - sfd_pkg::FracQ30)) >= op_r.mag_d;
        div_init.rem = op_r.mag_n >> (W - sfd_pkg::FracQ30);
        div_init.low = op_r.mag_n << sfd_pkg::FracQ30;
      end
      default: begin
        div_init.sat = (op_r.mag_n >> (W - 1 - sfd_pkg::FracQ16)) >= op_r.mag_d;
        div_init.rem = op_r.mag_n >> (W - sfd_pkg::FracQ16);
        div_init.low = op_r.mag_n << sfd_pkg::FracQ16;
      end
    endcase
  end

  for (genvar k = 0; k < N; k++) begin : g_div
    logic                prev_v;
    sfd_pkg::div_stage_t prev;
    logic                next_rdy;

    if (k == 0) begin : g_first
      assign prev_v = op_v_r;
      assign prev   = div_init;
    end else begin : g_mid
      assign prev_v = div_v_r[k-1];
      assign prev   = div_r[k-1];
    end

    if (k == N - 1) begin : g_last
      assign next_rdy = out_rdy;
    end else begin : g_inner
      assign next_rdy = div_rdy[k+1];
    end

    assign div_rdy[k] = !div_v_r[k] || next_rdy;

    always_comb begin
      div_nxt[k] = prev;
      for (int unsigned s = 0; s < sfd_pkg::StepsPerStage; s++) begin
        div_nxt[k] = sfd_pkg::div_step(div_nxt[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_v_r[k] <= 1'b0;
      end else if (div_rdy[k]) begin
        div_v_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (div_rdy[k]) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  always_comb begin
    if (div_r[N-1].sat) begin
      out_q_nxt = div_r[N-1].neg ? sfd_pkg::SatNeg : sfd_pkg::SatPos;
    end else if (div_r[N-1].neg) begin
      out_q_nxt = ~div_r[N-1].q + 1'b1;
    end else begin
      out_q_nxt = div_r[N-1].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= div_v_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_q_r <= out_q_nxt;
    end
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.quotient = out_q_r;

endmodule

/* hw/rtl/sfd_checker.sv */
// Port-level assertions for the fixed-point divider and their bind.
module sfd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sfd_pkg::DataW-1:0]   quotient
);

  localparam int unsigned CntW = $clog2(sfd_pkg::PipeDepth + 1);

  logic [CntW-1:0] inflight_r;
  logic            in_beat;
  logic            out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Beats accepted whose quotient has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_beat && !out_beat) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(quotient))
    else $error("quotient beat changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("quotient beat without an accepted operand beat");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CntW'(sfd_pkg::PipeDepth))
    else $error("more beats in flight than the pipeline holds");

endmodule

bind saturating_fixed_divider sfd_checker u_sfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .quotient  (out_chan.quotient)
);
